@@ rtl/core/cubic_hermite_spline_evaluator_assert.svh @@
// Assertion macros for the spline evaluator
`ifndef CUBIC_HERMITE_SPLINE_EVALUATOR_ASSERT_SVH
`define CUBIC_HERMITE_SPLINE_EVALUATOR_ASSERT_SVH
// implication checked on every clock edge outside reset
`define CHS_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define CHS_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ rtl/core/chs_pkg.sv @@
// ----------------------------------------------------------------------------
// chs_pkg
// Types and constants shared by the spline evaluator modules.
// ----------------------------------------------------------------------------
package chs_pkg;
  localparam int MaxDimsDef = 4;
  localparam int MaxSegsDef = 16;
  localparam logic [31:0] OneQ = 32'h0001_0000;
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StZeroDur = 2'd1;
  localparam logic [1:0] StBeyond = 2'd2;
  localparam logic [1:0] CfgStepTime = 2'd0;
  localparam logic [1:0] CfgNumDims = 2'd1;
  localparam logic [1:0] CfgNumSegs = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  dim_index;
    logic [3:0]  segment_index;
    logic signed [31:0] start_pos;
    logic signed [31:0] start_slope;
    logic signed [31:0] end_pos;
    logic signed [31:0] end_slope;
    logic [30:0] duration;
    logic [15:0] step_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  dim_out;
    logic [3:0]  segment_out;
    logic signed [31:0] value;
    logic signed [31:0] w_start_pos;
    logic signed [31:0] w_start_slope;
    logic signed [31:0] w_end_pos;
    logic signed [31:0] w_end_slope;
    logic        last;
  } rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LMUL0, S_LMUL1, S_DIV, S_LCOEF, S_LRES,
    S_TMUL, S_WALK, S_UMUL, S_U2, S_U3, S_WT0, S_WT1, S_WSAT,
    S_RD, S_H3, S_H2, S_H1, S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic lmul0;
    logic lmul1;
    logic div_start;
    logic lcoef;
    logic lres;
    logic tmul;
    logic walk_init;
    logic walk_step;
    logic umul;
    logic u2;
    logic u3;
    logic wt0;
    logic wt1;
    logic wsat;
    logic rd;
    logic h3;
    logic h2;
    logic h1;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_eval;
    logic zero_dur;
    logic div_done;
    logic walk_done;
    logic last_dim;
  } sts_t;

  // Q16.16 signed product, floor (arithmetic shift)
  function automatic logic signed [63:0] mulq(input logic signed [63:0] p);
    mulq = p >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) sat32 = 32'sh8000_0000;
    else sat32 = v[31:0];
  endfunction
endpackage

@@ rtl/core/chs_ctrl.sv @@
// ----------------------------------------------------------------------------
// chs_ctrl
// Sequencer for load and evaluate items.
// ----------------------------------------------------------------------------
module chs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  chs_pkg::sts_t     sts,
  output chs_pkg::cmd_t     cmd
);
  chs_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= chs_pkg::S_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != chs_pkg::S_IDLE);
    case (state)
      chs_pkg::S_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          state_next = chs_pkg::S_LMUL0;
        end
      end
      // the request is latched; branch on its type
      chs_pkg::S_LMUL0: begin
        if (sts.is_eval) begin
          cmd.tmul = 1'b1;
          state_next = chs_pkg::S_TMUL;
        end else if (sts.zero_dur) begin
          state_next = chs_pkg::S_LRES;
        end else begin
          cmd.lmul0 = 1'b1;
          state_next = chs_pkg::S_LMUL1;
        end
      end
      chs_pkg::S_LMUL1: begin
        cmd.lmul1 = 1'b1;
        cmd.div_start = 1'b1;
        state_next = chs_pkg::S_DIV;
      end
      chs_pkg::S_DIV: begin
        if (sts.div_done) state_next = chs_pkg::S_LCOEF;
      end
      chs_pkg::S_LCOEF: begin
        cmd.lcoef = 1'b1;
        state_next = chs_pkg::S_LRES;
      end
      chs_pkg::S_LRES: begin
        cmd.lres = 1'b1;
        state_next = chs_pkg::S_IDLE;
      end
      chs_pkg::S_TMUL: begin
        cmd.walk_init = 1'b1;
        state_next = chs_pkg::S_WALK;
      end
      chs_pkg::S_WALK: begin
        if (sts.walk_done) begin
          cmd.umul = 1'b1;
          state_next = chs_pkg::S_UMUL;
        end else cmd.walk_step = 1'b1;
      end
      chs_pkg::S_UMUL: begin
        cmd.u2 = 1'b1;
        state_next = chs_pkg::S_U2;
      end
      chs_pkg::S_U2: begin
        cmd.u3 = 1'b1;
        state_next = chs_pkg::S_U3;
      end
      chs_pkg::S_U3: begin
        cmd.wt0 = 1'b1;
        state_next = chs_pkg::S_WT0;
      end
      chs_pkg::S_WT0: begin
        cmd.wt1 = 1'b1;
        state_next = chs_pkg::S_WT1;
      end
      chs_pkg::S_WT1: begin
        cmd.wsat = 1'b1;
        state_next = chs_pkg::S_WSAT;
      end
      chs_pkg::S_WSAT: begin
        cmd.rd = 1'b1;
        state_next = chs_pkg::S_RD;
      end
      chs_pkg::S_RD: begin
        cmd.h3 = 1'b1;
        state_next = chs_pkg::S_H3;
      end
      chs_pkg::S_H3: begin
        cmd.h2 = 1'b1;
        state_next = chs_pkg::S_H2;
      end
      chs_pkg::S_H2: begin
        cmd.h1 = 1'b1;
        state_next = chs_pkg::S_H1;
      end
      chs_pkg::S_H1: begin
        cmd.emit = 1'b1;
        state_next = chs_pkg::S_EMIT;
      end
      chs_pkg::S_EMIT: begin
        if (sts.last_dim) state_next = chs_pkg::S_IDLE;
        else begin
          cmd.rd = 1'b1;
          state_next = chs_pkg::S_RD;
        end
      end
      default: state_next = chs_pkg::S_IDLE;
    endcase
  end
endmodule

@@ rtl/core/chs_div.sv @@
// ----------------------------------------------------------------------------
// chs_div
// Radix-2 restoring divider: floor(2^32 / d), saturated to 32 bits.
// ----------------------------------------------------------------------------
module chs_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [31:0] quot
);
  logic [5:0]  cnt;
  logic [32:0] q;
  logic [32:0] rem;
  logic [31:0] d;
  logic        run;
  logic [33:0] trial;

  // dividend is 1 followed by 32 zeros; one quotient bit per cycle
  assign trial = {rem, (cnt == 6'd33)} - {2'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 6'd33;
        rem <= '0;
        q <= '0;
        d <= {1'b0, divisor};
      end else if (run) begin
        if (!trial[33]) begin
          rem <= trial[32:0];
          q <= {q[31:0], 1'b1};
        end else begin
          rem <= {rem[31:0], (cnt == 6'd33)};
          q <= {q[31:0], 1'b0};
        end
        if (cnt == 6'd1) begin
          run <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end

  assign quot = q[32] ? 32'hFFFF_FFFF : q[31:0];
endmodule

@@ rtl/core/chs_dpath.sv @@
// ----------------------------------------------------------------------------
// chs_dpath
// Stores, multiplier paths and result formation.
// ----------------------------------------------------------------------------
module chs_dpath #(
  parameter int MAX_DIMS = chs_pkg::MaxDimsDef,
  parameter int MAX_SEGMENTS = chs_pkg::MaxSegsDef
) (
  input  logic          clk,
  input  logic          rst,
  input  chs_pkg::req_t req,
  input  chs_pkg::cmd_t cmd,
  input  logic [31:0]   sample_period,
  input  logic [2:0]    num_dims,
  input  logic [4:0]    num_segments,
  output chs_pkg::sts_t sts,
  output logic          done,
  output chs_pkg::rsp_t result
);
  localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int AW = DW + SW;
  localparam int DEPTH = MAX_DIMS * MAX_SEGMENTS;
  localparam int DLIM = (MAX_DIMS < 4) ? MAX_DIMS : 4;

  // coefficient memory, one word per coefficient set; durations per segment
  logic [127:0] coef_mem [DEPTH];
  logic [127:0] knot_mem [DEPTH];
  logic [31:0]  dur_mem [MAX_SEGMENTS];
  logic [31:0]  inv_mem [MAX_SEGMENTS];

  chs_pkg::req_t r;
  logic signed [63:0] tdx0, tdx1, acc;
  logic signed [63:0] dlt;
  logic [47:0] t;
  logic [47:0] base;
  logic [4:0]  scnt;
  logic [3:0]  nseg_m1;
  logic        found;
  logic [SW-1:0] seg;
  logic [31:0] tau;
  logic [32:0] u;
  logic [32:0] u2, u3;
  logic signed [63:0] wa, wb;
  logic signed [31:0] h00, h10, h01, h11;
  logic [2:0]  dim;
  logic [2:0]  nd;
  logic [127:0] cw;
  logic [31:0] tseg;
  logic [30:0] dur_rd;
  logic        div_done;
  logic [31:0] inv_q;
  logic        in_range;
  logic [63:0] up;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  chs_pkg::rsp_t res;
  logic        res_v;

  chs_div u_div (
    .clk(clk), .rst(rst), .go(cmd.div_start), .divisor(r.duration),
    .done(div_done), .quot(inv_q)
  );

  // effective counts
  always_comb begin
    nd = (num_dims == 3'd0) ? 3'd1 : num_dims;
    if (32'(nd) > DLIM) nd = 3'(DLIM);
    if (num_segments == 5'd0) nseg_m1 = 4'd0;
    else if (32'(num_segments) > MAX_SEGMENTS) nseg_m1 = 4'(MAX_SEGMENTS - 1);
    else nseg_m1 = 4'(num_segments - 5'd1);
  end

  assign in_range = (32'(r.dim_index) < MAX_DIMS) && (32'(r.segment_index) < MAX_SEGMENTS);
  assign dur_rd = dur_mem[SW'(scnt)][30:0];
  assign up = 64'(tau) * 64'(inv_mem[seg]);
  assign dlt = 64'(r.start_pos) - 64'(r.end_pos);
  // store address: dimension-major, one entry per segment
  assign wr_addr = AW'(32'(r.dim_index) * MAX_SEGMENTS + 32'(r.segment_index));
  assign rd_addr = AW'(32'(dim) * MAX_SEGMENTS + 32'(seg));

  always_ff @(posedge clk) begin
    if (cmd.load_req) r <= req;
    // load: slope times duration
    if (cmd.lmul0) tdx0 <= chs_pkg::mulq($signed({33'b0, r.duration}) * 64'(r.start_slope));
    if (cmd.lmul1) tdx1 <= chs_pkg::mulq($signed({33'b0, r.duration}) * 64'(r.end_slope));
    if (cmd.lcoef && in_range) begin
      coef_mem[wr_addr] <=
        {chs_pkg::sat32(64'sd2 * dlt + tdx0 + tdx1),
         chs_pkg::sat32(-(64'sd3 * dlt + 64'sd2 * tdx0 + tdx1)),
         chs_pkg::sat32(tdx0), r.start_pos};
      knot_mem[wr_addr] <=
        {r.end_slope, r.end_pos, r.start_slope, r.start_pos};
      dur_mem[SW'(r.segment_index)] <= {1'b0, r.duration};
      inv_mem[SW'(r.segment_index)] <= inv_q;
    end
    // evaluate: time and segment walk, one segment a cycle
    if (cmd.tmul) t <= 48'(r.step_index) * 48'(sample_period);
    if (cmd.walk_init) begin
      base <= '0;
      scnt <= '0;
      found <= 1'b0;
    end
    if (cmd.walk_step) begin
      if (t < base + 48'(dur_rd)) begin
        found <= 1'b1;
        seg <= SW'(scnt);
        tau <= 32'(t - base);
      end else begin
        base <= base + 48'(dur_rd);
        seg <= SW'(nseg_m1);
      end
      scnt <= scnt + 5'd1;
    end
    if (cmd.umul) begin
      if (!found) u <= 33'(chs_pkg::OneQ);
      else if (up[63:16] > 48'(chs_pkg::OneQ)) u <= 33'(chs_pkg::OneQ);
      else u <= up[48:16];
      tseg <= dur_mem[seg];
    end
    if (cmd.u2) u2 <= 33'((66'(u) * 66'(u)) >> 16);
    if (cmd.u3) u3 <= 33'((66'(u2) * 66'(u)) >> 16);
    if (cmd.wt0) wa <= chs_pkg::mulq(64'(tseg) *
                     (64'(u) - 64'sd2 * 64'(u2) + 64'(u3)));
    if (cmd.wt1) wb <= chs_pkg::mulq(64'(tseg) * (64'(u3) - 64'(u2)));
    if (cmd.wsat) begin
      h00 <= chs_pkg::sat32(64'(chs_pkg::OneQ) - 64'sd3 * 64'(u2) + 64'sd2 * 64'(u3));
      h10 <= chs_pkg::sat32(wa);
      h01 <= chs_pkg::sat32(64'sd3 * 64'(u2) - 64'sd2 * 64'(u3));
      h11 <= chs_pkg::sat32(wb);
      dim <= '0;
    end
    // Horner per dimension: registered read then three multiply-adds;
    // partial sums stay within 35 bits, so the multiplier takes 36 of them
    if (cmd.rd) cw <= coef_mem[rd_addr];
    if (cmd.h3) acc <= 64'($signed(cw[95:64])) +
                  chs_pkg::mulq($signed({31'b0, u}) * 64'($signed(cw[127:96])));
    if (cmd.h2) acc <= 64'($signed(cw[63:32])) +
                  chs_pkg::mulq($signed({31'b0, u}) * 64'($signed(acc[35:0])));
    if (cmd.h1) acc <= 64'($signed(cw[31:0])) +
                  chs_pkg::mulq($signed({31'b0, u}) * 64'($signed(acc[35:0])));
    if (cmd.emit) dim <= dim + 3'd1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) res_v <= 1'b0;
    else res_v <= cmd.lres | cmd.emit;
    if (cmd.lres) begin
      res.status <= (r.duration == 31'd0) ? chs_pkg::StZeroDur : chs_pkg::StOk;
      res.dim_out <= r.dim_index;
      res.segment_out <= r.segment_index;
      res.value <= '0;
      res.w_start_pos <= '0;
      res.w_start_slope <= '0;
      res.w_end_pos <= '0;
      res.w_end_slope <= '0;
      res.last <= 1'b1;
    end else if (cmd.emit) begin
      res.status <= found ? chs_pkg::StOk : chs_pkg::StBeyond;
      res.dim_out <= dim[1:0];
      res.segment_out <= 4'(seg);
      res.value <= chs_pkg::sat32(acc);
      res.w_start_pos <= h00;
      res.w_start_slope <= h10;
      res.w_end_pos <= h01;
      res.w_end_slope <= h11;
      res.last <= (dim + 3'd1 == nd);
    end
  end

  assign sts.is_eval = r.req_type;
  assign sts.zero_dur = (r.duration == 31'd0);
  assign sts.div_done = div_done;
  assign sts.walk_done = found || (scnt > 5'(nseg_m1));
  assign sts.last_dim = (dim == nd);
  assign done = res_v;
  assign result = res;
endmodule

@@ rtl/core/cubic_hermite_spline_evaluator.sv @@
// ----------------------------------------------------------------------------
// cubic_hermite_spline_evaluator
// Piecewise cubic Hermite trajectory store and evaluator, Q16.16.
// ----------------------------------------------------------------------------
// Usage: present an item on req and raise start; it transfers at a clock edge
// with start high and busy low. Results appear on result, each for one cycle
// with done high; result.last marks the final one of an item. The receiver
// cannot stall results. A load gives one result after the bit-serial reciprocal
// divider (33 steps) has run; a zero duration skips the divider. busy is already
// low while a load result is shown.
// An evaluate item walks w durations, one a cycle (w is the found segment plus
// one, or the segments in use when the time lies past the last one), forms the
// basis weights (u, its square and cube, the two slope weights, saturation) and
// then gives one result per dimension, each after a coefficient read, three
// Horner steps and output: the last result shows with busy still high, and the
// next item can transfer at the end of the following cycle.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle; the
// user must see to that, the block does not. Reset restores sample_period 6554,
// num_dims 1 and num_segments 1; stores hold nothing valid until loaded.
// ----------------------------------------------------------------------------
module cubic_hermite_spline_evaluator #(
  parameter int MAX_DIMS = chs_pkg::MaxDimsDef,
  parameter int MAX_SEGMENTS = chs_pkg::MaxSegsDef
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  chs_pkg::req_t req,
  output logic          done,
  output chs_pkg::rsp_t result,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  `include "cubic_hermite_spline_evaluator_assert.svh"

  logic [31:0] sample_period;
  logic [2:0]  num_dims;
  logic [4:0]  num_segments;
  chs_pkg::cmd_t cmd;
  chs_pkg::sts_t sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= 32'd6554;
      num_dims <= 3'd1;
      num_segments <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        chs_pkg::CfgStepTime: sample_period <= cfg_data;
        chs_pkg::CfgNumDims: num_dims <= cfg_data[2:0];
        chs_pkg::CfgNumSegs: num_segments <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  chs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  chs_dpath #(.MAX_DIMS(MAX_DIMS), .MAX_SEGMENTS(MAX_SEGMENTS)) u_dpath (
    .clk(clk), .rst(rst), .req(req), .cmd(cmd), .sample_period(sample_period),
    .num_dims(num_dims), .num_segments(num_segments), .sts(sts),
    .done(done), .result(result)
  );

  `CHS_ASSERT_NXT(a_start_busy, clk, rst, start && !busy, busy)
  `CHS_ASSERT_IMP(a_done_last_busy, clk, rst, done && !result.last, busy)
  `CHS_ASSERT_IMP(a_load_one, clk, rst, cmd.lres, !cmd.emit)
endmodule
